// ===== src/i2cmbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types, codes and helpers for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int unsigned TickW   = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ActW    = 3;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned CfgIdxW = 2;

  // command codes
  localparam logic [ActW-1:0] ACT_TICK  = 3'd0;
  localparam logic [ActW-1:0] ACT_START = 3'd1;
  localparam logic [ActW-1:0] ACT_STOP  = 3'd2;
  localparam logic [ActW-1:0] ACT_WRITE = 3'd3;
  localparam logic [ActW-1:0] ACT_READ  = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_SETUP  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HALF   = 2'd2;

  // register reset values
  localparam logic [TickW-1:0] SETUP_RST  = 8'd3;
  localparam logic [TickW-1:0] SETTLE_RST = 8'd2;
  localparam logic [TickW-1:0] HALF_RST   = 8'd5;

  localparam logic [BitCntW-1:0] DATA_BITS = 4'd8;
  localparam logic [BitCntW-1:0] SLOT_BITS = 4'd9;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_START_C,
    PH_STOP_A,
    PH_STOP_B,
    PH_STOP_C,
    PH_W_SETUP,
    PH_W_SETTLE,
    PH_W_HIGH,
    PH_R_SETUP,
    PH_R_SETTLE,
    PH_R_HIGH
  } phase_t;

  typedef struct packed {
    logic [TickW-1:0] setup_ticks;
    logic [TickW-1:0] data_settle_ticks;
    logic [TickW-1:0] half_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [ByteW-1:0] data_byte;
    logic             send_ack;
    logic             sda_in;
  } cmd_t;

  typedef struct packed {
    logic             scl_out;
    logic             sda_out;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_byte;
    logic             ack_received;
  } res_t;

  // length of a phase in ticks; a zero register acts as one tick
  function automatic logic [TickW-1:0] phase_len(phase_t ph, cfg_t cfg);
    logic [TickW-1:0] len;
    case (ph)
      PH_W_SETUP, PH_R_SETUP:   len = cfg.setup_ticks;
      PH_W_SETTLE, PH_R_SETTLE: len = cfg.data_settle_ticks;
      default:                  len = cfg.half_period_ticks;
    endcase
    if (len == '0) begin
      len = {{(TickW-1){1'b0}}, 1'b1};
    end
    return len;
  endfunction

endpackage

// ===== src/i2cmbe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_if
// Valid/ready channels of the I2C master bit engine: tick/command beats,
// result beats and register writes.
// ----------------------------------------------------------------------------
interface i2cmbe_cmd_if;
  import i2cmbe_pkg::*;
  logic             valid;
  logic             ready;
  logic [ActW-1:0]  action;
  logic [ByteW-1:0] data_byte;
  logic             send_ack;
  logic             sda_in;

  modport source (output valid, action, data_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, action, data_byte, send_ack, sda_in, output ready);
endinterface

interface i2cmbe_res_if;
  import i2cmbe_pkg::*;
  logic             valid;
  logic             ready;
  logic             scl_out;
  logic             sda_out;
  logic             busy_res;
  logic             done_res;
  logic [ByteW-1:0] read_byte;
  logic             ack_received;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, read_byte,
                  ack_received, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_byte,
                  ack_received, output ready);
endinterface

interface i2cmbe_cfg_if;
  import i2cmbe_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TickW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/i2c_master_bit_engine.sv =====
`timescale 1ns / 1ps
// A result beat is valid in the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle under a ready sink; the sequencer
//   update and result register sit in one pass, so the latter sets the rate.
// Reset (rst, synchronous, active high): bus lines released, sequencer idle,
//   result register empty, timing registers back to 3 / 2 / 5 ticks.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: each beat on cmd is one bus tick carrying an
// optional start, stop, write-byte or read-byte command and the sampled SDA.
// Each tick yields one result beat with the SCL/SDA drive levels and status.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  logic          clk,
  input  logic          rst,
  i2cmbe_cmd_if.sink    cmd,
  i2cmbe_res_if.source  res,
  i2cmbe_cfg_if.sink    cfg
);
  import i2cmbe_pkg::*;

  cfg_t regs;
  cmd_t cmd_beat;
  res_t res_next;
  logic step;

  // Timing registers. A new length applies from the next tick; a phase in
  // flight ends once its count reaches the current length.
  i2cmbe_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign cmd_beat.action    = cmd.action;
  assign cmd_beat.data_byte = cmd.data_byte;
  assign cmd_beat.send_ack  = cmd.send_ack;
  assign cmd_beat.sda_in    = cmd.sda_in;

  // A tick advances the sequencer only on the cycle its beat is taken.
  assign step = cmd.valid & cmd.ready;

  // Phase machine: start/stop holds and the nine-slot write/read bit cycles.
  i2cmbe_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cmd_beat (cmd_beat),
    .cfg      (regs),
    .res_next (res_next)
  );

  // Result register: takes a new beat while the previous one drains, so
  // ticks keep flowing at one per cycle under a ready sink.
  i2cmbe_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (cmd.valid),
    .load_ready (cmd.ready),
    .load_data  (res_next),
    .res        (res)
  );

`ifndef NO_ASSERTIONS
  // every accepted tick shows up as a result beat on the next cycle
  a_tick_to_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> res.valid)
    else $error("accepted tick produced no result beat");

  // an empty result register never stalls the tick channel
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !res.valid |-> cmd.ready)
    else $error("tick channel stalled with empty result register");

  // completion only ever ends a busy sequence
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.done_res) |-> res.busy_res)
    else $error("done without busy");

  // received byte and ack flag are only reported on a done beat
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.done_res) |-> (res.read_byte == '0 && !res.ack_received))
    else $error("read data or ack reported outside a done beat");
`endif

endmodule

// ===== src/i2cmbe_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_cfg_regs
// Timing registers: setup, data settle and half period tick counts.
// ----------------------------------------------------------------------------
module i2cmbe_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  i2cmbe_cfg_if.sink        cfg,
  output i2cmbe_pkg::cfg_t  regs
);
  import i2cmbe_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.setup_ticks       <= SETUP_RST;
      regs.data_settle_ticks <= SETTLE_RST;
      regs.half_period_ticks <= HALF_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_SETUP:  regs.setup_ticks       <= cfg.data;
        CFG_SETTLE: regs.data_settle_ticks <= cfg.data;
        CFG_HALF:   regs.half_period_ticks <= cfg.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

// ===== src/i2cmbe_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_seq
// Bit sequencer: advances the phase machine by one tick per accepted beat
// and forms that tick's result.
// ----------------------------------------------------------------------------
module i2cmbe_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  i2cmbe_pkg::cmd_t  cmd_beat,
  input  i2cmbe_pkg::cfg_t  cfg,
  output i2cmbe_pkg::res_t  res_next
);
  import i2cmbe_pkg::*;

  phase_t             phase, phase_next, ph_e;
  logic [TickW-1:0]   tick_count, tick_count_next, tc_e, tc_inc;
  logic [BitCntW-1:0] bit_count, bit_count_next, bc_e, bc_inc;
  logic [ByteW-1:0]   shift_reg, shift_reg_next, sr_e;
  logic               scl_level, scl_level_next, scl_e;
  logic               sda_level, sda_level_next, sda_e;
  logic               ack_flag, ack_flag_next, ackf_e;
  logic               ack_choice, ack_choice_next, ackc_e;
  logic               launch, phase_end;

  assign launch = (phase == PH_IDLE) &&
                  (cmd_beat.action == ACT_START || cmd_beat.action == ACT_STOP ||
                   cmd_beat.action == ACT_WRITE || cmd_beat.action == ACT_READ);

  // state as seen after a command is taken on an idle tick
  always_comb begin
    ph_e   = phase;
    tc_e   = tick_count;
    bc_e   = bit_count;
    sr_e   = shift_reg;
    scl_e  = scl_level;
    sda_e  = sda_level;
    ackf_e = ack_flag;
    ackc_e = ack_choice;
    if (launch) begin
      tc_e  = '0;
      scl_e = 1'b0;
      case (cmd_beat.action) inside
        ACT_START: ph_e = PH_START_A;
        ACT_STOP:  ph_e = PH_STOP_A;
        ACT_WRITE: begin
          sr_e   = cmd_beat.data_byte;
          bc_e   = '0;
          ackf_e = 1'b0;
          ph_e   = PH_W_SETUP;
        end
        default: begin
          sda_e  = 1'b1;
          sr_e   = '0;
          bc_e   = '0;
          ackc_e = cmd_beat.send_ack;
          ph_e   = PH_R_SETUP;
        end
      endcase
    end
  end

  assign tc_inc    = tc_e + 1'b1;
  assign bc_inc    = bc_e + 1'b1;
  assign phase_end = (ph_e != PH_IDLE) && (tc_inc >= phase_len(ph_e, cfg));

  // next phase
  always_comb begin
    phase_next = ph_e;
    if (phase_end) begin
      unique case (ph_e)
        PH_START_A:  phase_next = PH_START_B;
        PH_START_B:  phase_next = PH_START_C;
        PH_START_C:  phase_next = PH_IDLE;
        PH_STOP_A:   phase_next = PH_STOP_B;
        PH_STOP_B:   phase_next = PH_STOP_C;
        PH_STOP_C:   phase_next = PH_IDLE;
        PH_W_SETUP:  phase_next = PH_W_SETTLE;
        PH_W_SETTLE: phase_next = PH_W_HIGH;
        PH_W_HIGH:   phase_next = (bc_inc >= SLOT_BITS) ? PH_IDLE : PH_W_SETUP;
        PH_R_SETUP:  phase_next = PH_R_SETTLE;
        PH_R_SETTLE: phase_next = PH_R_HIGH;
        PH_R_HIGH:   phase_next = (bc_inc >= SLOT_BITS) ? PH_IDLE : PH_R_SETUP;
        default:     phase_next = PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    tick_count_next = tc_e;
    bit_count_next  = bc_e;
    shift_reg_next  = sr_e;
    scl_level_next  = scl_e;
    sda_level_next  = sda_e;
    ack_flag_next   = ackf_e;
    ack_choice_next = ackc_e;
    res_next          = '0;
    res_next.scl_out  = scl_e;
    res_next.sda_out  = sda_e;
    res_next.busy_res = (ph_e != PH_IDLE);
    if (ph_e != PH_IDLE) begin
      tick_count_next = phase_end ? '0 : tc_inc;
    end
    if (phase_end) begin
      unique case (ph_e)
        PH_START_A, PH_STOP_B: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
        end
        PH_START_B: sda_level_next = 1'b0;
        PH_START_C: begin
          scl_level_next    = 1'b0;
          res_next.done_res = 1'b1;
        end
        PH_STOP_A: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b0;
        end
        PH_STOP_C: res_next.done_res = 1'b1;
        PH_W_SETUP: begin
          if (bc_e < DATA_BITS) begin
            sda_level_next = sr_e[ByteW-1];
            shift_reg_next = {sr_e[ByteW-2:0], 1'b0};
          end
        end
        PH_W_SETTLE, PH_R_SETTLE: scl_level_next = 1'b1;
        PH_W_HIGH: begin
          if (bc_e >= DATA_BITS) begin
            ack_flag_next = ~cmd_beat.sda_in;
          end
          bit_count_next = bc_inc;
          scl_level_next = 1'b0;
          if (bc_inc >= SLOT_BITS) begin
            res_next.done_res     = 1'b1;
            res_next.ack_received = ack_flag_next;
          end else if (bc_inc == DATA_BITS) begin
            sda_level_next = 1'b1;  // release for the slave's ack
          end
        end
        PH_R_SETUP: begin
          if (bc_e >= DATA_BITS) begin
            sda_level_next = ~ackc_e;
          end
        end
        PH_R_HIGH: begin
          if (bc_e < DATA_BITS) begin
            shift_reg_next = {sr_e[ByteW-2:0], cmd_beat.sda_in};
          end
          bit_count_next = bc_inc;
          scl_level_next = 1'b0;
          if (bc_inc >= SLOT_BITS) begin
            res_next.done_res  = 1'b1;
            res_next.read_byte = shift_reg_next;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_count  <= '0;
      shift_reg  <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      ack_flag   <= 1'b0;
      ack_choice <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      ack_flag   <= ack_flag_next;
      ack_choice <= ack_choice_next;
    end
  end

endmodule

// ===== src/i2cmbe_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_out_reg
// Result register with valid/ready; loads whenever empty or being drained.
// ----------------------------------------------------------------------------
module i2cmbe_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  output logic              load_ready,
  input  i2cmbe_pkg::res_t  load_data,
  i2cmbe_res_if.source      res
);
  import i2cmbe_pkg::*;

  res_t held;

  assign load_ready = ~res.valid | res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_ready) begin
      res.valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      held <= load_data;
    end
  end

  assign res.scl_out      = held.scl_out;
  assign res.sda_out      = held.sda_out;
  assign res.busy_res     = held.busy_res;
  assign res.done_res     = held.done_res;
  assign res.read_byte    = held.read_byte;
  assign res.ack_received = held.ack_received;

endmodule
